FILE: design/hfl_pkg.sv
// hfl_pkg: shared types, constants and log-domain arithmetic for the hmm forward unit
// no dependencies
`default_nettype none
package hfl_pkg;

  localparam int NUM_STATES  = 8;
  localparam int NUM_SYMBOLS = 16;
  localparam int PROB_WIDTH  = 16;

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int SYM_W   = $clog2(NUM_SYMBOLS);
  localparam int CORR_LEN = 39;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - PROB_WIDTH - 1;

  typedef logic signed [PROB_WIDTH-1:0] prob_t;
  typedef logic signed [PROB_WIDTH:0]   wide_t;

  localparam prob_t P_MIN = {1'b1, {(PROB_WIDTH-1){1'b0}}};
  localparam wide_t W_MAX = {2'b00, {(PROB_WIDTH-1){1'b1}}};
  localparam wide_t W_MIN = {2'b11, {(PROB_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_LOAD_TRANS = 2'd0,
    FUNC_LOAD_EMIS  = 2'd1,
    FUNC_LOAD_INIT  = 2'd2,
    FUNC_OBSERVE    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_UPDATE,
    S_TOTAL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic               shift;
    logic               acc_clr;
    logic               acc_en;
    logic               upd;
    logic               first;
    logic [STATE_W-1:0] step;
    logic [SYM_W-1:0]   sym;
    logic               sym_ok;
  } hfl_ctrl_t;

  typedef struct packed {
    logic               trans;
    logic               emis;
    logic               init;
    logic [STATE_W-1:0] row;
    logic [STATE_W-1:0] dst;
    logic [SYM_W-1:0]   col;
    prob_t              value;
  } hfl_wr_t;

  function automatic logic [8:0] corr_lut(input logic [5:0] k);
    logic [8:0] c;
    unique case (k)
      6'd0:  c = 9'd256; 6'd1:  c = 9'd225; 6'd2:  c = 9'd198; 6'd3:  c = 9'd172;
      6'd4:  c = 9'd150; 6'd5:  c = 9'd130; 6'd6:  c = 9'd112; 6'd7:  c = 9'd96;
      6'd8:  c = 9'd82;  6'd9:  c = 9'd70;  6'd10: c = 9'd60;  6'd11: c = 9'd51;
      6'd12: c = 9'd44;  6'd13: c = 9'd37;  6'd14: c = 9'd31;  6'd15: c = 9'd26;
      6'd16: c = 9'd22;  6'd17: c = 9'd19;  6'd18: c = 9'd16;  6'd19: c = 9'd13;
      6'd20: c = 9'd11;  6'd21: c = 9'd10;  6'd22: c = 9'd8;   6'd23: c = 9'd7;
      6'd24: c = 9'd6;   6'd25: c = 9'd5;   6'd26: c = 9'd4;   6'd27: c = 9'd3;
      6'd28: c = 9'd3;   6'd29: c = 9'd2;   6'd30: c = 9'd2;   6'd31: c = 9'd2;
      6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38: c = 9'd1;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic prob_t P_MAX_f();
    return W_MAX[PROB_WIDTH-1:0];
  endfunction

  function automatic prob_t lmul(input prob_t a, input prob_t b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    if (a == P_MIN || b == P_MIN) return P_MIN;
    if (s > W_MAX) return P_MAX_f();
    if (s < W_MIN) return P_MIN;
    return s[PROB_WIDTH-1:0];
  endfunction

  function automatic prob_t ladd(input prob_t a, input prob_t b);
    wide_t                 m;
    wide_t                 n;
    wide_t                 s;
    logic [PROB_WIDTH:0]   d;
    logic [PROB_WIDTH-6:0] k;
    logic [8:0]            c;
    logic [PROB_WIDTH:0]   cz;
    m  = (a > b) ? wide_t'(a) : wide_t'(b);
    n  = (a > b) ? wide_t'(b) : wide_t'(a);
    d  = m - n;
    k  = d[PROB_WIDTH:6];
    c  = (k < CORR_LEN) ? corr_lut(k[5:0]) : 9'd0;
    cz = (PROB_WIDTH+1)'(c);
    s  = m + $signed(cz);
    if (a == P_MIN) return b;
    if (b == P_MIN) return a;
    if (s > W_MAX) return P_MAX_f();
    return s[PROB_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/hfl_cell.sv
// hfl_cell: one state of the forward recursion, holds alpha, its transition column,
// emission row, initial entry and accumulator; depends on hfl_pkg
`default_nettype none
module hfl_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [hfl_pkg::STATE_W-1:0] cell_id,
  input  wire hfl_pkg::hfl_ctrl_t          ctrl,
  input  wire hfl_pkg::hfl_wr_t            wr,
  input  wire hfl_pkg::prob_t              alpha_in,
  input  wire hfl_pkg::prob_t              head,
  output hfl_pkg::prob_t                   alpha
);

  hfl_pkg::prob_t trans [hfl_pkg::NUM_STATES];
  hfl_pkg::prob_t emis  [hfl_pkg::NUM_SYMBOLS];
  hfl_pkg::prob_t init;
  hfl_pkg::prob_t acc;
  hfl_pkg::prob_t src;

  assign src   = ctrl.first ? init : acc;

  always_ff @(posedge clk) begin
    if (wr.trans && wr.dst == cell_id) begin
      trans[wr.row] <= wr.value;
    end
    if (wr.emis && wr.row == cell_id) begin
      emis[wr.col] <= wr.value;
    end
    if (wr.init && wr.row == cell_id) begin
      init <= wr.value;
    end
    if (ctrl.acc_clr) begin
      acc <= hfl_pkg::P_MIN;
    end else if (ctrl.acc_en) begin
      acc <= hfl_pkg::ladd(acc, hfl_pkg::lmul(head, trans[ctrl.step]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= hfl_pkg::P_MIN;
    end else if (ctrl.upd) begin
      alpha <= hfl_pkg::lmul(src, ctrl.sym_ok ? emis[ctrl.sym] : hfl_pkg::P_MIN);
    end else if (ctrl.shift) begin
      alpha <= alpha_in;
    end
  end

endmodule
`default_nettype wire

FILE: design/hmm_forward_likelihood_unit.sv
// hmm_forward_likelihood_unit: top level, sequencer, ring of hfl_cell and result register
// depends on hfl_pkg and hfl_cell
//
// channel  dir  tdata                                         tuser   tlast
// s_*      in   row_index, col_index, table_value, obs_symbol,  func    seq_last
//               seq_first
// m_*      out  log_likelihood, zero_probability              -       -
//
// a load word is accepted in the idle state; an observe word with seq_first goes straight to the update,
// otherwise it first accumulates over one ring rotation through the shared head
// a closing word then sums the total over one more rotation
// the result waits in the output register while new words are accepted
// a closing word stalls before its load while the previous result is unread
// synchronous reset sets alpha to the zero floor; tables are undefined until loaded
`default_nettype none
module hmm_forward_likelihood_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [hfl_pkg::IN_DATA_W-1:0]    s_tdata,  // row, col, value, symbol, first
  input  wire logic [1:0]                       s_tuser,  // func
  input  wire logic                             s_tlast,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [hfl_pkg::OUT_DATA_W-1:0]        m_tdata   // log_likelihood, zero_probability
);

  localparam int N  = hfl_pkg::NUM_STATES;
  localparam int SW = hfl_pkg::STATE_W;
  localparam logic [SW-1:0] LAST_STEP = SW'(N - 1);

  hfl_pkg::state_t    state, state_next;
  hfl_pkg::hfl_ctrl_t ctrl;
  hfl_pkg::hfl_wr_t   wr;
  hfl_pkg::func_t     in_func;
  hfl_pkg::prob_t     alpha_vec [N];
  hfl_pkg::prob_t     total;
  hfl_pkg::prob_t     ll;
  logic               zp;
  logic [SW-1:0]      cnt;
  logic               first_q, last_q, sym_ok_q;
  logic [hfl_pkg::SYM_W-1:0] sym_q;
  logic [2:0]         in_row;
  logic [3:0]         in_col;
  logic [3:0]         in_sym;
  logic               in_first;
  logic               accept;
  logic               is_obs;
  logic               out_load;

  assign in_func  = hfl_pkg::func_t'(s_tuser);
  assign in_row   = s_tdata[2:0];
  assign in_col   = s_tdata[6:3];
  assign in_sym   = s_tdata[26:23];
  assign in_first = s_tdata[27];
  assign s_tready = (state == hfl_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_obs   = (in_func == hfl_pkg::FUNC_OBSERVE);

  always_comb begin
    wr.trans = accept && in_func == hfl_pkg::FUNC_LOAD_TRANS && int'(in_row) < N
               && int'(in_col) < N;
    wr.emis  = accept && in_func == hfl_pkg::FUNC_LOAD_EMIS && int'(in_row) < N
               && int'(in_col) < hfl_pkg::NUM_SYMBOLS;
    wr.init  = accept && in_func == hfl_pkg::FUNC_LOAD_INIT && int'(in_row) < N;
    wr.row   = SW'(in_row);
    wr.dst   = SW'(in_col);
    wr.col   = hfl_pkg::SYM_W'(in_col);
    wr.value = s_tdata[22:7];
  end

  always_ff @(posedge clk) begin
    if (accept && is_obs) begin
      first_q  <= in_first;
      last_q   <= s_tlast;
      sym_q    <= hfl_pkg::SYM_W'(in_sym);
      sym_ok_q <= int'(in_sym) < hfl_pkg::NUM_SYMBOLS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctrl.shift   = 1'b0;
    ctrl.acc_clr = accept && is_obs;
    ctrl.acc_en  = 1'b0;
    ctrl.upd     = 1'b0;
    ctrl.first   = first_q;
    ctrl.step    = cnt;
    ctrl.sym     = sym_q;
    ctrl.sym_ok  = sym_ok_q;
    out_load     = 1'b0;
    unique case (state)
      hfl_pkg::S_IDLE: begin
        if (accept && is_obs) begin
          state_next = in_first ? hfl_pkg::S_UPDATE : hfl_pkg::S_ACCUM;
        end
      end
      hfl_pkg::S_ACCUM: begin
        ctrl.shift  = 1'b1;
        ctrl.acc_en = 1'b1;
        if (cnt == LAST_STEP) state_next = hfl_pkg::S_UPDATE;
      end
      hfl_pkg::S_UPDATE: begin
        ctrl.upd   = 1'b1;
        state_next = last_q ? hfl_pkg::S_TOTAL : hfl_pkg::S_IDLE;
      end
      hfl_pkg::S_TOTAL: begin
        ctrl.shift = 1'b1;
        if (cnt == LAST_STEP) state_next = hfl_pkg::S_OUT;
      end
      hfl_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = hfl_pkg::S_IDLE;
        end
      end
      default: state_next = hfl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == hfl_pkg::S_ACCUM || state == hfl_pkg::S_TOTAL) begin
      cnt <= (cnt == LAST_STEP) ? '0 : cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hfl_pkg::S_UPDATE) begin
      total <= hfl_pkg::P_MIN;
    end else if (state == hfl_pkg::S_TOTAL) begin
      total <= hfl_pkg::ladd(total, alpha_vec[0]);
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    hfl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (SW'(g)),
      .ctrl     (ctrl),
      .wr       (wr),
      .alpha_in (alpha_vec[(g + 1) % N]),
      .head     (alpha_vec[0]),
      .alpha    (alpha_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ll <= total;
      zp <= (total == hfl_pkg::P_MIN);
    end
  end

  assign m_tdata = {{hfl_pkg::OUT_PAD_W{1'b0}}, zp, ll};

`ifndef SYNTH
  a_accum_to_update: assert property (@(posedge clk) disable iff (rst)
    (state == hfl_pkg::S_ACCUM && cnt == LAST_STEP) |=> state == hfl_pkg::S_UPDATE)
    else $error("accumulation did not end after one rotation");
  a_no_result_midseq: assert property (@(posedge clk) disable iff (rst)
    (state == hfl_pkg::S_UPDATE && !last_q) |=> state == hfl_pkg::S_IDLE)
    else $error("unexpected total pass");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (zp == (ll == hfl_pkg::P_MIN)))
    else $error("zero flag mismatch");
  a_out_from_total: assert property (@(posedge clk) disable iff (rst)
    out_load |-> $past(state == hfl_pkg::S_TOTAL) || $past(state == hfl_pkg::S_OUT))
    else $error("result loaded without total pass");
`endif

endmodule
`default_nettype wire
